// ----- rtl/ich_pkg.sv -----
`default_nettype none

package ich_pkg;

    // Length counter width; the count itself needs one more bit to hold the saturation value.
    localparam int LENGTH_WIDTH = 16;
    localparam int CNT_W        = LENGTH_WIDTH + 1;

    localparam logic [CNT_W-1:0]        CNT_SAT  = {1'b1, {LENGTH_WIDTH{1'b0}}};
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX  = '1;
    localparam logic [15:0]             SEG_MAX  = 16'hFFFF;
    localparam logic [15:0]             ODD_MASK = 16'hFF00;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic FUNC_ADDR = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_USE_PH   = 8'd0,
        REG_PROTOCOL = 8'd1,
        REG_ZERO_EN  = 8'd2,
        REG_ZERO_IDX = 8'd3
    } cfg_index_t;

    typedef struct packed {
        logic        use_ph;
        logic [7:0]  protocol;
        logic        zero_en;
        logic [14:0] zero_idx;
    } cfg_t;

    // One classified word handed from front to back.
    typedef struct packed {
        logic [15:0]             word;
        logic                    last;
        logic                    ph_en;
        logic [LENGTH_WIDTH-1:0] len;
        logic                    over;
        logic [15:0]             seg;
    } entry_t;

endpackage

`default_nettype wire

// ----- rtl/internet_checksum_pseudo_header_core.sv -----
`default_nettype none

// Internet checksum engine with optional pseudo-header. Stream one packet as 16-bit
// big-endian words, one word per clock: tuser selects address word (0) or data word (1),
// tlast marks the final word. The block accepts one word every cycle while the queue is not
// full; the rate is set by the single ones-complement adder in the back stage. Once the back
// stage pops the last word from the queue, the result is registered and held in an output
// register, while the front keeps taking the next packet into a two-entry queue; a last word
// that finds the previous result still waiting stays in the queue, and the input stalls once
// the queue holds two words. The data byte count is kept internally, the checksum word
// position is forced to zero when enabled, and protocol plus length are added at packet end
// when the pseudo-header is on. Write configuration only while no packet is in flight.
module internet_checksum_pseudo_header_core
    import ich_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [23:0]            s_tdata,   // [15:0] data_word, [16] odd_byte, rest zero
    input  wire logic                   s_tlast,   // last
    input  wire logic                   s_tuser,   // func
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [39:0]                 m_tdata    // [15:0] checksum, [31:16] segment_length,
                                                   // [32] length_overflow, rest zero
);

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   push;
    logic   full;
    logic   pop;
    logic   head_valid;
    entry_t wr_entry;
    entry_t head;
    logic [15:0] checksum;
    logic [15:0] segment_length;
    logic        length_overflow;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_USE_PH:   cfg_next.use_ph   = cfg_data[0];
                REG_PROTOCOL: cfg_next.protocol = cfg_data[7:0];
                REG_ZERO_EN:  cfg_next.zero_en  = cfg_data[0];
                REG_ZERO_IDX: cfg_next.zero_idx = cfg_data[14:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.use_ph   <= 1'b1;
            cfg_reg.protocol <= 8'd6;
            cfg_reg.zero_en  <= 1'b1;
            cfg_reg.zero_idx <= 15'd8;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ich_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .func      (s_tuser),
        .data_word (s_tdata[15:0]),
        .odd_byte  (s_tdata[16]),
        .last      (s_tlast),
        .full      (full),
        .push      (push),
        .entry     (wr_entry)
    );

    ich_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_entry   (wr_entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    ich_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .checksum        (checksum),
        .segment_length  (segment_length),
        .length_overflow (length_overflow)
    );

    assign m_tdata = {7'b0, length_overflow, segment_length, checksum};

endmodule

`default_nettype wire

// ----- rtl/ich_front.sv -----
`default_nettype none

module ich_front
    import ich_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic        func,
    input  wire logic [15:0] data_word,
    input  wire logic        odd_byte,
    input  wire logic        last,
    input  wire logic        full,
    output logic             push,
    output entry_t           entry
);

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    is_data;
    logic                    odd_eff;
    logic                    hit;
    logic [LENGTH_WIDTH-2:0] idx_ext;
    logic [15:0]             word_m;
    logic [CNT_W:0]          cnt_sum;
    logic [CNT_W-1:0]        cnt_upd;
    logic [CNT_W-1:0]        cnt_fin;

    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    assign is_data = (func == FUNC_DATA);
    assign odd_eff = last && odd_byte;
    assign idx_ext = (LENGTH_WIDTH-1)'(cfg.zero_idx);
    assign word_m  = odd_eff ? (data_word & ODD_MASK) : data_word;

    // Word position is the byte count halved; no match once the count has saturated.
    assign hit = cfg.zero_en && !count_reg[LENGTH_WIDTH]
                 && (count_reg[LENGTH_WIDTH-1:1] == idx_ext);

    assign cnt_sum = {1'b0, count_reg} + (odd_eff ? (CNT_W+1)'(1) : (CNT_W+1)'(2));
    assign cnt_upd = (cnt_sum > {1'b0, CNT_SAT}) ? CNT_SAT : cnt_sum[CNT_W-1:0];
    assign cnt_fin = is_data ? cnt_upd : count_reg;

    always_comb
    begin
        entry.word  = data_word;
        if (is_data)
        begin
            entry.word = hit ? 16'h0000 : word_m;
        end
        entry.last  = last;
        entry.ph_en = cfg.use_ph;
        entry.over  = cnt_fin[LENGTH_WIDTH];
        entry.len   = cnt_fin[LENGTH_WIDTH] ? LEN_MAX : cnt_fin[LENGTH_WIDTH-1:0];
        entry.seg   = (cnt_fin > CNT_W'(SEG_MAX)) ? SEG_MAX : cnt_fin[15:0];
    end

    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            count_next = last ? '0 : cnt_fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ich_queue.sv -----
`default_nettype none

module ich_queue
    import ich_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t wr_entry,
    output logic        full,
    input  wire logic   pop,
    output logic        head_valid,
    output entry_t      head
);

    entry_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ich_back.sv -----
`default_nettype none

module ich_back
    import ich_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        head_valid,
    input  wire entry_t      head,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      checksum,
    output logic [15:0]      segment_length,
    output logic             length_overflow
);

    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic        valid_reg;
    logic        valid_next;
    logic [15:0] csum_reg;
    logic [15:0] seg_reg;
    logic        over_reg;
    logic        ph_add;
    logic [31:0] len32;
    logic [18:0] total;
    logic [16:0] fold1;
    logic [15:0] fold2;

    // Hold a last word until the result register is free.
    assign pop = head_valid && (!head.last || !valid_reg || m_tready);

    assign ph_add = head.last && head.ph_en;
    assign len32  = 32'(head.len);

    // Ones-complement add of up to five words; two folds absorb all carries.
    assign total = 19'(sum_reg) + 19'(head.word)
                 + (ph_add ? (19'(cfg.protocol) + 19'(len32[15:0]) + 19'(len32[31:16]))
                           : 19'd0);
    assign fold1 = 17'(total[15:0]) + 17'(total[18:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);

    always_comb
    begin
        sum_next   = sum_reg;
        valid_next = valid_reg && !m_tready;
        if (pop)
        begin
            sum_next = head.last ? 16'h0000 : fold2;
            if (head.last)
            begin
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            csum_reg <= ~fold2;
            seg_reg  <= head.seg;
            over_reg <= head.over;
        end
    end

    assign m_tvalid        = valid_reg;
    assign checksum        = csum_reg;
    assign segment_length  = seg_reg;
    assign length_overflow = over_reg;

`ifndef NO_ASSERTIONS
    a_rose_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> $past(pop && head.last))
        else $error("result valid without a last word");

    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.last) |=> (sum_reg == 16'h0000))
        else $error("running sum not cleared after packet end");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !m_tready) |-> !(pop && head.last))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
